>>> design/lidar_point_box_assigner_defines.svh
// Assertion macros used by the checker file.
`ifndef LIDAR_POINT_BOX_ASSIGNER_DEFINES_SVH
`define LIDAR_POINT_BOX_ASSIGNER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define LPBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpba same-cycle check failed");

// Next-cycle implication, also checked during reset.
`define LPBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lpba next-cycle check failed");

`endif

>>> design/lpba_pkg.sv
`timescale 1ns / 1ps
package lpba_pkg;

  typedef enum logic [1:0] {
    CMD_COEF  = 2'd0,
    CMD_BOX   = 2'd1,
    CMD_POINT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [3:0]         slot_index;
    logic               slot_valid;
    logic [11:0]        box_left;
    logic [11:0]        box_top;
    logic [11:0]        box_width;
    logic [11:0]        box_height;
    logic signed [23:0] point_fwd;
    logic signed [23:0] point_left;
    logic signed [23:0] point_up;
  } in_t;

  typedef struct packed {
    logic               assigned;
    logic [3:0]         box_slot;
    logic [4:0]         boxes_hit;
    logic signed [15:0] pixel_col;
    logic signed [15:0] pixel_row;
    logic               zero_depth;
    logic               saturated;
  } out_t;

  localparam int NUM_COEFS = 12;
  localparam int PROD_W    = 56;
  localparam int ACC_W     = 58;
  localparam int QBITS     = 17;
  localparam int CMP_W     = ACC_W + QBITS;
  localparam logic [7:0] SHRINK_RESET = 8'd26;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             neg_u;
    logic             neg_v;
    logic             ovf_u;
    logic             ovf_v;
    logic [ACC_W-1:0] dmag;
    logic [ACC_W-1:0] rem_u;
    logic [ACC_W-1:0] rem_v;
    logic [QBITS-1:0] q_u;
    logic [QBITS-1:0] q_v;
  } div_t;

endpackage

>>> design/lidar_point_box_assigner.sv
`timescale 1ns / 1ps
// Lidar point to box assigner.
// Command channel (cmd_valid / cmd_stall / cmd_data): writes projection
// coefficients, writes box slots, or classifies a lidar point. Writes take
// effect when accepted and give no result; a write waits (cmd_stall high)
// until no point is in flight. Points stream at one per cycle unless
// stalled. Result channel (res_valid / res_stall / res_data): one result
// per point. The pipeline is 3 product/sum/setup stages, the 17-stage
// restoring divider (one quotient bit per stage), a saturate stage, the box
// test stage and the output register. The user must write shrink_factor
// via cfg_we / cfg_wdata only while idle; the block does not enforce it.
// Reset: coefficients zero, all slots empty, shrink_factor 26, no result.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module lidar_point_box_assigner #(
  parameter int BOX_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  lpba_pkg::in_t cmd_data,
  output logic          res_valid,
  input  logic          res_stall,
  output lpba_pkg::out_t res_data,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);
  import lpba_pkg::*;

  localparam int CNT_W  = $clog2(BOX_SLOTS + 1);
  localparam int SLOT_W = (BOX_SLOTS > 1) ? $clog2(BOX_SLOTS) : 1;

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] r;
    r = x[ACC_W-1] ? (~x + 1'b1) : x;
    return r;
  endfunction

  // {sat, value}
  function automatic logic [16:0] clip(input logic neg, input logic ovf,
                                       input logic [QBITS-1:0] q);
    logic [16:0] r;
    if (ovf) begin
      r = neg ? {1'b1, 16'h8000} : {1'b1, 16'h7fff};
    end else if (!neg) begin
      r = (q > 17'd32767) ? {1'b1, 16'h7fff} : {1'b0, q[15:0]};
    end else begin
      r = (q > 17'd32768) ? {1'b1, 16'h8000} : {1'b0, 16'(16'd0 - q[15:0])};
    end
    return r;
  endfunction

  logic       advance, busy, accept, is_write;
  logic [7:0] shrink;

  logic signed [31:0] coefs [NUM_COEFS];

  logic        box_vld [BOX_SLOTS];
  logic [11:0] box_l [BOX_SLOTS];
  logic [11:0] box_t [BOX_SLOTS];
  logic [11:0] box_w [BOX_SLOTS];
  logic [11:0] box_h [BOX_SLOTS];

  // shrunk boxes, registered from the store
  logic        sb_vld [BOX_SLOTS];
  logic [12:0] sb_x [BOX_SLOTS];
  logic [12:0] sb_y [BOX_SLOTS];
  logic [13:0] sb_xe [BOX_SLOTS];
  logic [13:0] sb_ye [BOX_SLOTS];

  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_p [3][3];
  logic signed [31:0]       s1_c3 [3];
  logic                     s2_valid;
  logic signed [ACC_W-1:0]  s2_acc [3];
  div_t                     div [QBITS+1];

  logic               sat_valid, sat_zero, sat_sat;
  logic signed [15:0] sat_col, sat_row;

  logic               tst_valid, tst_zero, tst_sat;
  logic signed [15:0] tst_col, tst_row;
  logic [BOX_SLOTS-1:0] tst_hit;

  logic [CNT_W-1:0]  hit_cnt;
  logic [SLOT_W-1:0] hit_first;
  logic [ACC_W-1:0]  umag, vmag, dmag;
  logic [16:0]       col_c, row_c;
  logic              div_busy;

  assign advance  = !res_valid || !res_stall;
  assign is_write = (cmd_data.command == CMD_COEF) || (cmd_data.command == CMD_BOX);

  always_comb begin
    div_busy = 1'b0;
    for (int k = 0; k <= QBITS; k++) begin
      div_busy = div_busy | div[k].valid;
    end
  end

  assign busy      = s1_valid | s2_valid | div_busy | sat_valid | tst_valid;
  assign cmd_stall = !advance || (is_write && busy);
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      shrink <= SHRINK_RESET;
    end else if (cfg_we) begin
      shrink <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coefs[i] <= '0;
      end
    end else if (accept && cmd_data.command == CMD_COEF &&
                 32'(cmd_data.coef_index) < NUM_COEFS) begin
      coefs[cmd_data.coef_index] <= cmd_data.coef_value;
    end
  end

  for (genvar i = 0; i < BOX_SLOTS; i++) begin : g_box
    logic [19:0] off_x, off_y;
    logic [19:0] len_w, len_h;
    logic        wr;

    assign wr = accept && cmd_data.command == CMD_BOX &&
                32'(cmd_data.slot_index) == i;

    always_ff @(posedge clk) begin
      if (rst) begin
        box_vld[i] <= 1'b0;
        sb_vld[i]  <= 1'b0;
      end else begin
        if (wr) begin
          box_vld[i] <= cmd_data.slot_valid;
        end
        sb_vld[i] <= box_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (wr) begin
        box_l[i] <= cmd_data.box_left;
        box_t[i] <= cmd_data.box_top;
        box_w[i] <= cmd_data.box_width;
        box_h[i] <= cmd_data.box_height;
      end
    end

    assign off_x = 20'(shrink) * 20'(box_w[i]);
    assign off_y = 20'(shrink) * 20'(box_h[i]);
    assign len_w = 20'(9'd256 - 9'(shrink)) * 20'(box_w[i]);
    assign len_h = 20'(9'd256 - 9'(shrink)) * 20'(box_h[i]);

    always_ff @(posedge clk) begin
      sb_x[i]  <= 13'(box_l[i]) + 13'(off_x[19:9]);
      sb_y[i]  <= 13'(box_t[i]) + 13'(off_y[19:9]);
      sb_xe[i] <= 14'(13'(box_l[i]) + 13'(off_x[19:9])) + 14'(len_w[19:8]);
      sb_ye[i] <= 14'(13'(box_t[i]) + 13'(off_y[19:9])) + 14'(len_h[19:8]);
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept && cmd_data.command == CMD_POINT;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        s1_p[r][0] <= PROD_W'(coefs[r*4])     * PROD_W'(cmd_data.point_fwd);
        s1_p[r][1] <= PROD_W'(coefs[r*4 + 1]) * PROD_W'(cmd_data.point_left);
        s1_p[r][2] <= PROD_W'(coefs[r*4 + 2]) * PROD_W'(cmd_data.point_up);
        s1_c3[r]   <= coefs[r*4 + 3];
      end
    end
  end

  // row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        s2_acc[r] <= ACC_W'(s1_p[r][0]) + ACC_W'(s1_p[r][1]) + ACC_W'(s1_p[r][2]) +
                     (ACC_W'(s1_c3[r]) <<< 12);
      end
    end
  end

  // divider setup: magnitudes, signs, quotient overflow
  assign umag = mag(s2_acc[0]);
  assign vmag = mag(s2_acc[1]);
  assign dmag = mag(s2_acc[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      div[0].valid <= 1'b0;
    end else if (advance) begin
      div[0].valid <= s2_valid;
      div[0].zero  <= (s2_acc[2] == '0);
      div[0].neg_u <= s2_acc[0][ACC_W-1] ^ s2_acc[2][ACC_W-1];
      div[0].neg_v <= s2_acc[1][ACC_W-1] ^ s2_acc[2][ACC_W-1];
      div[0].ovf_u <= {{QBITS{1'b0}}, umag} >= {dmag, {QBITS{1'b0}}};
      div[0].ovf_v <= {{QBITS{1'b0}}, vmag} >= {dmag, {QBITS{1'b0}}};
      div[0].dmag  <= dmag;
      div[0].rem_u <= umag;
      div[0].rem_v <= vmag;
      div[0].q_u   <= '0;
      div[0].q_v   <= '0;
    end
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int B = QBITS - 1 - k;
    logic [CMP_W-1:0] dsh;
    logic             ge_u, ge_v;
    div_t             nxt;

    assign dsh  = CMP_W'(div[k].dmag) << B;
    assign ge_u = CMP_W'(div[k].rem_u) >= dsh;
    assign ge_v = CMP_W'(div[k].rem_v) >= dsh;

    always_comb begin
      nxt = div[k];
      if (ge_u) begin
        nxt.rem_u  = div[k].rem_u - dsh[ACC_W-1:0];
        nxt.q_u[B] = 1'b1;
      end
      if (ge_v) begin
        nxt.rem_v  = div[k].rem_v - dsh[ACC_W-1:0];
        nxt.q_v[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div[k+1].valid <= 1'b0;
      end else if (advance) begin
        div[k+1] <= nxt;
      end
    end
  end

  // sign and saturation
  assign col_c = clip(div[QBITS].neg_u, div[QBITS].ovf_u, div[QBITS].q_u);
  assign row_c = clip(div[QBITS].neg_v, div[QBITS].ovf_v, div[QBITS].q_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_valid <= 1'b0;
    end else if (advance) begin
      sat_valid <= div[QBITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat_zero <= div[QBITS].zero;
      sat_sat  <= !div[QBITS].zero && (col_c[16] || row_c[16]);
      sat_col  <= div[QBITS].zero ? 16'sd0 : $signed(col_c[15:0]);
      sat_row  <= div[QBITS].zero ? 16'sd0 : $signed(row_c[15:0]);
    end
  end

  // half-open containment test per slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tst_valid <= 1'b0;
    end else if (advance) begin
      tst_valid <= sat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tst_zero <= sat_zero;
      tst_sat  <= sat_sat;
      tst_col  <= sat_col;
      tst_row  <= sat_row;
      for (int i = 0; i < BOX_SLOTS; i++) begin
        tst_hit[i] <= sb_vld[i] && !sat_zero &&
                      (17'(sat_col) >= $signed({4'b0, sb_x[i]})) &&
                      (17'(sat_col) <  $signed({3'b0, sb_xe[i]})) &&
                      (17'(sat_row) >= $signed({4'b0, sb_y[i]})) &&
                      (17'(sat_row) <  $signed({3'b0, sb_ye[i]}));
      end
    end
  end

  always_comb begin
    hit_cnt   = '0;
    hit_first = '0;
    for (int i = BOX_SLOTS - 1; i >= 0; i--) begin
      hit_cnt = hit_cnt + CNT_W'(tst_hit[i]);
      if (tst_hit[i]) begin
        hit_first = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= tst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data.assigned   <= (hit_cnt == CNT_W'(1));
      res_data.box_slot   <= (hit_cnt == CNT_W'(1)) ? 4'(hit_first) : 4'd0;
      res_data.boxes_hit  <= (32'(hit_cnt) > 31) ? 5'd31 : 5'(hit_cnt);
      res_data.pixel_col  <= tst_col;
      res_data.pixel_row  <= tst_row;
      res_data.zero_depth <= tst_zero;
      res_data.saturated  <= tst_sat;
    end
  end

endmodule

>>> design/lpba_checker.sv
`timescale 1ns / 1ps
`include "lidar_point_box_assigner_defines.svh"
module lpba_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input lpba_pkg::out_t res_data
);
  import lpba_pkg::*;

  `LPBA_ASSERT_NEXT(a_rst_clears, rst, !res_valid)
  `LPBA_ASSERT_NEXT(a_stall_holds, res_valid && res_stall && !rst, res_valid && $stable(res_data))
  `LPBA_ASSERT_IMPL(a_zero_clean, res_valid && res_data.zero_depth, !res_data.assigned && res_data.boxes_hit == 5'd0 && !res_data.saturated)
  `LPBA_ASSERT_IMPL(a_assign_one, res_valid && res_data.assigned, res_data.boxes_hit == 5'd1)

endmodule

bind lidar_point_box_assigner lpba_checker u_lpba_checker (.*);
